[rtl/stcf_pkg.sv]
`default_nettype none
package stcf_pkg;

	// field widths
	localparam int CHW     = 7;
	localparam int TIME_W  = 32;
	localparam int INDEX_W = 31;
	localparam int WIN_W   = 16;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_FRONT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_BACK   = 2'd2;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd16;

	// default channel count
	localparam int CHANNELS_DEF = 128;

	// item kinds
	localparam logic [1:0] KIND_HIT   = 2'd0;
	localparam logic [1:0] KIND_FLUSH = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// which channel a time lookup addresses
	typedef enum logic [1:0] {
		TSEL_SELF  = 2'd0,
		TSEL_LEFT  = 2'd1,
		TSEL_RIGHT = 2'd2
	} tsel_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  clr_all;
		logic  rd_time;
		tsel_t tsel;
		logic  begin_close;
		logic  step_back;
		logic  step_fwd;
		logic  emit_init;
		logic  rd_index;
		logic  emit;
		logic  store;
		logic  finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       item_ok;
		logic       self_active;
		logic       has_left;
		logic       has_right;
		logic       expired;
		logic       back_go;
		logic       fwd_go;
		logic       at_stop;
		logic       can_push;
		logic       hold_v;
	} sts_t;

endpackage
`default_nettype wire

[rtl/stcf_ctrl.sv]
`default_nettype none
module stcf_ctrl
	import stcf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	typedef enum logic [13:0] {
		S_IDLE      = 14'b00000000000001,
		S_DISPATCH  = 14'b00000000000010,
		S_CHK_SELF  = 14'b00000000000100,
		S_NB_LEFT   = 14'b00000000001000,
		S_CHK_LEFT  = 14'b00000000010000,
		S_NB_RIGHT  = 14'b00000000100000,
		S_CHK_RIGHT = 14'b00000001000000,
		S_CL_INIT   = 14'b00000010000000,
		S_SCAN_BACK = 14'b00000100000000,
		S_SCAN_FWD  = 14'b00001000000000,
		S_EMIT_RD   = 14'b00010000000000,
		S_EMIT_WR   = 14'b00100000000000,
		S_STORE     = 14'b01000000000000,
		S_FINISH    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		cmd.tsel = TSEL_SELF;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.kind == KIND_CLEAR) begin
					cmd.clr_all = 1'b1;
					state_d     = S_IDLE;
				end else if (!sts.item_ok) begin
					state_d = S_IDLE;
				end else if (sts.kind == KIND_FLUSH) begin
					cmd.rd_time = 1'b1;
					if (sts.self_active) begin
						ret_d   = S_FINISH;
						state_d = S_CL_INIT;
					end else begin
						state_d = S_IDLE;
					end
				end else if (sts.kind == KIND_HIT) begin
					if (sts.self_active) begin
						cmd.rd_time = 1'b1;
						state_d     = S_CHK_SELF;
					end else begin
						state_d = S_NB_LEFT;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_CHK_SELF: begin
				if (sts.expired) begin
					ret_d   = S_NB_LEFT;
					state_d = S_CL_INIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_NB_LEFT: begin
				if (sts.has_left) begin
					cmd.rd_time = 1'b1;
					cmd.tsel    = TSEL_LEFT;
					state_d     = S_CHK_LEFT;
				end else begin
					state_d = S_NB_RIGHT;
				end
			end
			S_CHK_LEFT: begin
				if (sts.expired) begin
					ret_d   = S_NB_RIGHT;
					state_d = S_CL_INIT;
				end else begin
					state_d = S_NB_RIGHT;
				end
			end
			S_NB_RIGHT: begin
				if (sts.has_right) begin
					cmd.rd_time = 1'b1;
					cmd.tsel    = TSEL_RIGHT;
					state_d     = S_CHK_RIGHT;
				end else begin
					state_d = S_STORE;
				end
			end
			S_CHK_RIGHT: begin
				if (sts.expired) begin
					ret_d   = S_STORE;
					state_d = S_CL_INIT;
				end else begin
					state_d = S_STORE;
				end
			end
			S_CL_INIT: begin
				cmd.begin_close = 1'b1;
				state_d         = S_SCAN_BACK;
			end
			S_SCAN_BACK: begin
				if (sts.back_go) begin
					cmd.step_back = 1'b1;
				end else begin
					state_d = S_SCAN_FWD;
				end
			end
			S_SCAN_FWD: begin
				if (sts.fwd_go) begin
					cmd.step_fwd = 1'b1;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_index = 1'b1;
				state_d      = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (sts.can_push) begin
					cmd.emit = 1'b1;
					state_d  = sts.at_stop ? ret_q : S_EMIT_RD;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.hold_v || sts.can_push) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_FINISH;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule
`default_nettype wire

[rtl/stcf_dp.sv]
`default_nettype none
module stcf_dp
	import stcf_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item fields
	input  wire logic [1:0]           kind,
	input  wire logic [CHW-1:0]       strip_channel,
	input  wire logic [TIME_W-1:0]    hit_time,
	input  wire logic [INDEX_W-1:0]   hit_index,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// control
	input  cmd_t                      cmd,
	output sts_t                      sts,
	// results
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CHW-1:0]            member_channel,
	output logic [INDEX_W-1:0]        member_index,
	output logic [CHW-1:0]            cluster_first,
	output logic [CHW-1:0]            cluster_last,
	output logic                      end_of_cluster,
	output logic                      end_of_run
);

	localparam int IDX_W = $clog2(CHANNELS);
	localparam logic [IDX_W-1:0] HALF_I  = IDX_W'(CHANNELS / 2);
	localparam logic [IDX_W-1:0] HALF_M1 = IDX_W'(CHANNELS / 2 - 1);
	localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(CHANNELS - 1);
	localparam logic [IDX_W-1:0] ZERO_I  = '0;
	localparam logic [CHW:0]     CH_LIM  = (CHW + 1)'(CHANNELS);

	function automatic logic [IDX_W-1:0] side_lo(input logic [IDX_W-1:0] x);
		return (x >= HALF_I) ? HALF_I : ZERO_I;
	endfunction

	function automatic logic [IDX_W-1:0] side_hi(input logic [IDX_W-1:0] x);
		return (x >= HALF_I) ? LAST_I : HALF_M1;
	endfunction

	function automatic logic [IDX_W-1:0] next_ch(input logic [IDX_W-1:0] x);
		return (x == side_hi(x)) ? side_lo(x) : x + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] prev_ch(input logic [IDX_W-1:0] x);
		return (x == side_lo(x)) ? side_hi(x) : x - 1'b1;
	endfunction

	// configuration registers
	logic [WIN_W-1:0] window_q;
	logic             wrap_front_q;
	logic             wrap_back_q;

	// item registers
	logic [1:0]         kind_q;
	logic               ok_q;
	logic [IDX_W-1:0]   c_q;
	logic [TIME_W-1:0]  t_q;
	logic [INDEX_W-1:0] idx_q;

	// channel state and stores
	logic [CHANNELS-1:0] active_q;
	logic [TIME_W-1:0]   time_mem [CHANNELS];
	logic [INDEX_W-1:0]  index_mem [CHANNELS];
	logic [TIME_W-1:0]   rdt_q;
	logic [INDEX_W-1:0]  rdi_q;

	// cluster walk registers
	logic [IDX_W-1:0] tgt_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] stop_q;
	logic [IDX_W-1:0] steps_q;
	logic [IDX_W-1:0] ch_q;

	// held and output results
	logic               hold_v_q;
	logic [IDX_W-1:0]   hold_ch_q;
	logic [INDEX_W-1:0] hold_idx_q;
	logic [IDX_W-1:0]   hold_first_q;
	logic [IDX_W-1:0]   hold_last_q;
	logic               hold_eoc_q;
	logic               out_v_q;
	logic [IDX_W-1:0]   out_ch_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [IDX_W-1:0]   out_first_q;
	logic [IDX_W-1:0]   out_last_q;
	logic               out_eoc_q;
	logic               out_eor_q;

	logic [IDX_W-1:0]  taddr;
	logic              wrap;
	logic [IDX_W-1:0]  pstart;
	logic [IDX_W-1:0]  nstop;
	logic [TIME_W-1:0] tdiff;
	logic              can_push;
	logic              move;

	// time lookup address
	always_comb begin
		case (cmd.tsel)
			TSEL_LEFT:  taddr = c_q - 1'b1;
			TSEL_RIGHT: taddr = c_q + 1'b1;
			default:    taddr = c_q;
		endcase
	end

	assign wrap   = (tgt_q >= HALF_I) ? wrap_back_q : wrap_front_q;
	assign pstart = prev_ch(start_q);
	assign nstop  = next_ch(stop_q);
	assign tdiff  = t_q - rdt_q;

	assign can_push = !out_v_q || out_ready;
	assign move     = hold_v_q && (cmd.emit || cmd.finish);

	// status towards the controller
	always_comb begin
		sts.kind        = kind_q;
		sts.item_ok     = ok_q;
		sts.self_active = active_q[c_q];
		sts.has_left    = (c_q != ZERO_I) && (c_q != HALF_I);
		sts.has_right   = (c_q != HALF_M1) && (c_q != LAST_I);
		sts.expired     = active_q[tgt_q] && (tdiff > TIME_W'(window_q));
		sts.back_go     = wrap ? ((steps_q < (side_hi(tgt_q) - side_lo(tgt_q)))
		                          && active_q[pstart])
		                       : ((start_q != side_lo(tgt_q)) && active_q[pstart]);
		sts.fwd_go      = wrap ? ((nstop != start_q) && active_q[nstop])
		                       : ((stop_q != side_hi(tgt_q)) && active_q[nstop]);
		sts.at_stop     = (ch_q == stop_q);
		sts.can_push    = can_push;
		sts.hold_v      = hold_v_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			wrap_front_q <= 1'b0;
			wrap_back_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIME_WINDOW: window_q     <= cfg_data;
				CFG_WRAP_FRONT:  wrap_front_q <= cfg_data[0];
				CFG_WRAP_BACK:   wrap_back_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item capture and cluster walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			ok_q   <= ({1'b0, strip_channel} < CH_LIM);
			c_q    <= strip_channel[IDX_W-1:0];
			t_q    <= hit_time;
			idx_q  <= hit_index;
		end
		if (cmd.rd_time) begin
			tgt_q <= taddr;
		end
		if (cmd.begin_close) begin
			start_q <= tgt_q;
			stop_q  <= tgt_q;
			steps_q <= '0;
		end
		if (cmd.step_back) begin
			start_q <= pstart;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.step_fwd) begin
			stop_q <= nstop;
		end
		if (cmd.emit_init) begin
			ch_q <= start_q;
		end else if (cmd.emit) begin
			ch_q <= next_ch(ch_q);
		end
	end

	// active flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.clr_all) begin
			active_q <= '0;
		end else if (cmd.emit) begin
			active_q[ch_q] <= 1'b0;
		end else if (cmd.store) begin
			active_q[c_q] <= 1'b1;
		end
	end

	// time store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			time_mem[c_q] <= t_q;
		end
		if (cmd.rd_time) begin
			rdt_q <= time_mem[taddr];
		end
	end

	// index store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			index_mem[c_q] <= idx_q;
		end
		if (cmd.rd_index) begin
			rdi_q <= index_mem[ch_q];
		end
	end

	// one member held back until it is known whether it ends the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (cmd.emit) begin
			hold_v_q <= 1'b1;
		end else if (cmd.finish) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_ch_q    <= ch_q;
			hold_idx_q   <= rdi_q;
			hold_first_q <= start_q;
			hold_last_q  <= stop_q;
			hold_eoc_q   <= (ch_q == stop_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_ch_q    <= hold_ch_q;
			out_idx_q   <= hold_idx_q;
			out_first_q <= hold_first_q;
			out_last_q  <= hold_last_q;
			out_eoc_q   <= hold_eoc_q;
			out_eor_q   <= cmd.finish;
		end
	end

	assign out_valid      = out_v_q;
	assign member_channel = CHW'(out_ch_q);
	assign member_index   = out_idx_q;
	assign cluster_first  = CHW'(out_first_q);
	assign cluster_last   = CHW'(out_last_q);
	assign end_of_cluster = out_eoc_q;
	assign end_of_run     = out_eor_q;

endmodule
`default_nettype wire

[rtl/strip_time_cluster_finder_unit.sv]
// A new item is accepted only while the controller is idle, so items are taken one at a time.
// Closing a cluster scans the active flags backward and then forward, one channel per step, then
// reads each member from the index store and emits it, waiting while the output is stalled.
// The last result of an item is held back and moves into the output register when the item finishes.
// Reset clears the active flags and loads the register defaults at once; the time and
// index stores are not cleared and their contents are only used behind an active flag.
`default_nettype none
module strip_time_cluster_finder_unit
	import stcf_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           kind,
	input  wire logic [CHW-1:0]       strip_channel,
	input  wire logic [TIME_W-1:0]    hit_time,
	input  wire logic [INDEX_W-1:0]   hit_index,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CHW-1:0]            member_channel,
	output logic [INDEX_W-1:0]        member_index,
	output logic [CHW-1:0]            cluster_first,
	output logic [CHW-1:0]            cluster_last,
	output logic                      end_of_cluster,
	output logic                      end_of_run
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencer
	stcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// channel state, stores and result path
	stcf_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.strip_channel  (strip_channel),
		.hit_time       (hit_time),
		.hit_index      (hit_index),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.member_channel (member_channel),
		.member_index   (member_index),
		.cluster_first  (cluster_first),
		.cluster_last   (cluster_last),
		.end_of_cluster (end_of_cluster),
		.end_of_run     (end_of_run)
	);

endmodule
`default_nettype wire

[test/tb_strip_time_cluster_finder_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_strip_time_cluster_finder_unit;
	import stcf_pkg::*;

	localparam int NCH  = 128;
	localparam int HALF = NCH / 2;

	typedef struct packed {
		logic [CHW-1:0]     ch;
		logic [INDEX_W-1:0] idx;
		logic [CHW-1:0]     first;
		logic [CHW-1:0]     last;
		logic               eoc;
		logic               eor;
	} member_t;

	typedef struct {
		logic [1:0]         kind;
		logic [CHW-1:0]     ch;
		logic [TIME_W-1:0]  t;
		logic [INDEX_W-1:0] idx;
		int                 n_exp;  // members typed in, -1 for predictor only
		member_t            m0;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [CHW-1:0] strip_channel = '0;
	logic [TIME_W-1:0] hit_time = '0;
	logic [INDEX_W-1:0] hit_index = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHW-1:0] member_channel;
	logic [INDEX_W-1:0] member_index;
	logic [CHW-1:0] cluster_first;
	logic [CHW-1:0] cluster_last;
	logic end_of_cluster;
	logic end_of_run;

	strip_time_cluster_finder_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .strip_channel(strip_channel),
		.hit_time(hit_time), .hit_index(hit_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.member_channel(member_channel), .member_index(member_index),
		.cluster_first(cluster_first), .cluster_last(cluster_last),
		.end_of_cluster(end_of_cluster), .end_of_run(end_of_run)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [WIN_W-1:0] window;
	logic wrap_front, wrap_back;
	logic active [NCH];
	logic [INDEX_W-1:0] idx_store [NCH];
	logic [TIME_W-1:0] time_store [NCH];
	member_t pending_members [$];
	int errors = 0;
	int mismatches = 0;
	bit stim_done = 0;
	int hold_off = 0;   // long receiver stall, in cycles
	logic [TIME_W-1:0] now_t = '0;

	function automatic int lo_of(int c);
		return c < HALF ? 0 : HALF;
	endfunction

	function automatic int hi_of(int c);
		return c < HALF ? HALF - 1 : NCH - 1;
	endfunction

	function automatic int step_up(int c);
		return c == hi_of(c) ? lo_of(c) : c + 1;
	endfunction

	function automatic int step_down(int c);
		return c == lo_of(c) ? hi_of(c) : c - 1;
	endfunction

	function automatic bit stale(int c, logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] d;
		d = t - time_store[c];
		return active[c] && d > {16'd0, window};
	endfunction

	// walk the run of active channels round c and queue its members
	task automatic close_cluster(int c);
		int lo, hi, n, start, stop, steps, ch;
		bit wr;
		member_t m;
		if (!active[c])
			return;
		lo = lo_of(c);
		hi = hi_of(c);
		n = hi - lo + 1;
		wr = c < HALF ? wrap_front : wrap_back;
		start = c;
		stop = c;
		if (!wr) begin
			while (start > lo && active[start-1])
				start--;
			while (stop < hi && active[stop+1])
				stop++;
		end else begin
			steps = 0;
			while (steps + 1 < n && active[step_down(start)]) begin
				start = step_down(start);
				steps++;
			end
			while (step_up(stop) != start && active[step_up(stop)])
				stop = step_up(stop);
		end
		ch = start;
		forever begin
			m.ch = ch;
			m.idx = idx_store[ch];
			m.first = start;
			m.last = stop;
			m.eoc = ch == stop;
			m.eor = 1'b0;
			pending_members.push_back(m);
			active[ch] = 1'b0;
			if (ch == stop)
				break;
			ch = step_up(ch);
		end
	endtask

	// work out the members one item releases
	task automatic predict_item(logic [1:0] k, int c, logic [TIME_W-1:0] t,
			logic [INDEX_W-1:0] ix);
		int before_n;
		before_n = pending_members.size();
		if (k == KIND_CLEAR) begin
			foreach (active[i])
				active[i] = 1'b0;
			return;
		end
		if (k != KIND_HIT && k != KIND_FLUSH)
			return;
		if (k == KIND_FLUSH) begin
			close_cluster(c);
		end else begin
			if (active[c]) begin
				if (!stale(c, t))
					return;
				close_cluster(c);
			end
			if (c != 0 && c != HALF && stale(c - 1, t))
				close_cluster(c - 1);
			if (c != HALF - 1 && c != NCH - 1 && stale(c + 1, t))
				close_cluster(c + 1);
			active[c] = 1'b1;
			idx_store[c] = ix;
			time_store[c] = t;
		end
		if (pending_members.size() > before_n)
			pending_members[$].eor = 1'b1;
	endtask

	task automatic report(string what, member_t e, member_t a);
		mismatches++;
		errors++;
		if (mismatches <= 10)
			$display({"mismatch %s: exp ch=%0d idx=%0d first=%0d last=%0d eoc=%0b eor=%0b,",
				" got ch=%0d idx=%0d first=%0d last=%0d eoc=%0b eor=%0b"},
				what, e.ch, e.idx, e.first, e.last, e.eoc, e.eor,
				a.ch, a.idx, a.first, a.last, a.eoc, a.eor);
	endtask

	// result checker
	always @(posedge clk) begin
		member_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{member_channel, member_index, cluster_first, cluster_last,
				end_of_cluster, end_of_run};
			if (pending_members.size() == 0) begin
				report("unexpected", '0, got);
			end else begin
				want = pending_members.pop_front();
				if (got !== want)
					report("field", want, got);
			end
		end
	end

	// receiver stalls
	initial begin
		int g;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				hold_off--;
			end else begin
				g = $urandom_range(0, 99);
				if (g < 60)
					out_ready <= 1'b1;
				else if (g < 97)
					out_ready <= $urandom_range(0, 1);
				else
					hold_off = $urandom_range(10, 60);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_W-1:0] v);
		cfg_index = r;
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (r == CFG_TIME_WINDOW)
			window = v;
		else if (r == CFG_WRAP_FRONT)
			wrap_front = v[0];
		else if (r == CFG_WRAP_BACK)
			wrap_back = v[0];
	endtask

	task automatic drain;
		while (pending_members.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic random_gap;
		int g;
		g = $urandom_range(0, 99);
		if (g < 55)
			return;
		else if (g < 95)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		else
			repeat ($urandom_range(10, 40)) @(negedge clk);
	endtask

	task automatic send(logic [1:0] k, logic [CHW-1:0] c, logic [TIME_W-1:0] t,
			logic [INDEX_W-1:0] ix);
		kind = k;
		strip_channel = c;
		hit_time = t;
		hit_index = ix;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_item(k, c, t, ix);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic settle_config(logic [15:0] w, logic f, logic b);
		drain();
		write_reg(CFG_TIME_WINDOW, w);
		write_reg(CFG_WRAP_FRONT, {15'd0, f});
		write_reg(CFG_WRAP_BACK, {15'd0, b});
	endtask

	// random hit, mostly in a few small neighbourhoods so clusters form
	task automatic random_hit;
		int c, r;
		r = $urandom_range(0, 99);
		if (r < 40)
			c = $urandom_range(0, 5);
		else if (r < 70)
			c = $urandom_range(HALF - 4, HALF + 3);
		else if (r < 80)
			c = NCH - 1 - $urandom_range(0, 4);
		else
			c = $urandom_range(0, NCH - 1);
		r = $urandom_range(0, 99);
		if (r < 60)
			now_t = now_t + $urandom_range(0, 8);
		else if (r < 90)
			now_t = now_t + $urandom_range(9, 100);
		else if (r < 95)
			now_t = $urandom;
		send(KIND_HIT, c, now_t, $urandom);
		random_gap();
	endtask

	// directed rows: members typed in where obvious
	row_t rows [$];

	task automatic add_row(logic [1:0] k, int c, logic [TIME_W-1:0] t,
			logic [INDEX_W-1:0] ix, int n, member_t m);
		row_t r;
		r = '{k, c, t, ix, n, m};
		rows.push_back(r);
	endtask

	initial begin
		int i, ph;
		member_t none;
		none = '0;
		window = WINDOW_RESET;
		wrap_front = 1'b0;
		wrap_back = 1'b0;
		foreach (active[i]) begin
			active[i] = 1'b0;
			idx_store[i] = '0;
			time_store[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// flush of empty channel, kind 3, hit then flush, extremes of fields
		add_row(KIND_FLUSH, 0, 0, 0, 0, none);
		add_row(2'd3, 5, 0, 0, 0, none);
		add_row(KIND_HIT, 0, 32'hFFFF_FFF0, 31'h7FFF_FFFF, 0, none);
		add_row(KIND_FLUSH, 0, 0, 0, 1, '{7'd0, 31'h7FFF_FFFF, 7'd0, 7'd0, 1'b1, 1'b1});
		add_row(KIND_HIT, 127, 32'hFFFF_FFFF, 31'h0, 0, none);
		add_row(KIND_FLUSH, 127, 0, 0, 1, '{7'd127, 31'h0, 7'd127, 7'd127, 1'b1, 1'b1});
		// three adjacent hits, duplicate within window, then flush middle
		add_row(KIND_HIT, 10, 100, 31'h15555555, 0, none);
		add_row(KIND_HIT, 11, 101, 31'h2AAAAAAA, 0, none);
		add_row(KIND_HIT, 12, 102, 31'h3, 0, none);
		add_row(KIND_HIT, 11, 110, 31'h9, 0, none);
		add_row(KIND_FLUSH, 11, 0, 0, -1, none);
		// expired self, expired neighbours, time going backwards
		add_row(KIND_HIT, 63, 200, 1, 0, none);
		add_row(KIND_HIT, 64, 200, 2, 0, none);
		add_row(KIND_HIT, 62, 300, 3, -1, none);
		add_row(KIND_HIT, 63, 400, 4, -1, none);
		add_row(KIND_HIT, 63, 10, 5, -1, none);
		add_row(KIND_HIT, 65, 10, 6, -1, none);
		add_row(KIND_CLEAR, 0, 0, 0, 0, none);
		add_row(KIND_FLUSH, 63, 0, 0, 0, none);
		add_row(KIND_HIT, 2, 32'h0000FFFF, 7, 0, none);
		add_row(KIND_CLEAR, 127, 0, 0, 0, none);

		for (i = 0; i < rows.size(); i++) begin
			if (rows[i].n_exp >= 0 && pending_members.size() == 0) begin
				send(rows[i].kind, rows[i].ch, rows[i].t, rows[i].idx);
				// typed-in expectation replaces the predictor's
				if (rows[i].n_exp == 1 && pending_members.size() == 1)
					pending_members[0] = rows[i].m0;
				else if (pending_members.size() != rows[i].n_exp)
					errors++;
			end else begin
				send(rows[i].kind, rows[i].ch, rows[i].t, rows[i].idx);
			end
			random_gap();
		end

		// full-side wrap: fill the front side, then close it
		settle_config(16'd0, 1'b1, 1'b0);
		for (i = 0; i < HALF; i++)
			send(KIND_HIT, i, 1000, i);
		send(KIND_FLUSH, 20, 0, 0);
		// edge-wrapping back cluster
		settle_config(16'd65535, 1'b1, 1'b1);
		send(KIND_HIT, 127, 5, 1);
		send(KIND_HIT, 64, 5, 2);
		send(KIND_HIT, 65, 5, 3);
		send(KIND_FLUSH, 64, 0, 0);

		// random phases under several settings
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: settle_config(16'd16, 1'b0, 1'b0);
				1: settle_config(16'd0, 1'b1, 1'b0);
				2: settle_config(16'd65535, 1'b0, 1'b1);
				3: settle_config($urandom_range(1, 40), 1'b1, 1'b1);
				default: settle_config(16'd4, $urandom_range(0, 1), $urandom_range(0, 1));
			endcase
			for (i = 0; i < 15; i++) begin
				if ($urandom_range(0, 99) < 8)
					send(KIND_FLUSH, $urandom_range(0, NCH - 1), $urandom, $urandom);
				else if ($urandom_range(0, 99) < 2)
					send($urandom_range(2, 3), $urandom, $urandom, $urandom);
				else
					random_hit();
				if (i == 10)
					hold_off = 150;
			end
			// in phase 2 the sender pauses until all results are in
			if (ph == 2)
				drain();
		end
		send(KIND_CLEAR, 0, 0, 0);
		drain();
		stim_done = 1;
	end

	// end of run
	initial begin
		wait (stim_done);
		@(negedge clk);
		if (errors == 0 && pending_members.size() == 0)
			$display("[strip_time_cluster_finder_unit] OK");
		else
			$display("[strip_time_cluster_finder_unit] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("[strip_time_cluster_finder_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/stcf_pkg.sv
rtl/stcf_ctrl.sv
rtl/stcf_dp.sv
rtl/strip_time_cluster_finder_unit.sv
test/tb_strip_time_cluster_finder_unit.sv
